// ----- hw/rtl/gbmr_pkg.sv -----
package gbmr_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int CELL_PIXELS_DEF = 10;

    localparam int POS_W   = 13;
    localparam int QUO_W   = POS_W + 1;
    localparam int KIND_W  = 3;
    localparam int RAD_W   = 7;
    localparam int CFG_W   = 7;
    localparam int ROW_W   = 6;
    localparam int MASK_W  = 64;
    localparam int OP_W    = 8;
    localparam int SQ_W    = 14;
    localparam int DIST_W  = 12;

    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_CELL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ROW  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISC = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RING = 3'd4;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_CHECK,
        S_RSQ,
        S_RSQ1,
        S_CSQ,
        S_ROWSQ,
        S_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- hw/rtl/gbmr_divider.sv -----
module gbmr_divider #(
    parameter int CELL_PIXELS = gbmr_pkg::CELL_PIXELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [gbmr_pkg::POS_W-1:0]  dividend,
    output logic signed [gbmr_pkg::QUO_W-1:0]  quotient,
    output gbmr_pkg::div_status_t              status
);

    // reciprocal multiplication, exact for every magnitude of POS_W bits
    localparam int SH_W    = $clog2(CELL_PIXELS);
    localparam int SHIFT   = gbmr_pkg::POS_W + SH_W;
    localparam int RECIP_W = gbmr_pkg::POS_W + 2;
    localparam int PROD_W  = SHIFT + gbmr_pkg::POS_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** SHIFT) + CELL_PIXELS - 1) / CELL_PIXELS);

    logic                               run_reg, run_next;
    logic                               done_reg, done_next;
    logic                               neg_reg, neg_next;
    logic [gbmr_pkg::POS_W-1:0]         mag_reg, mag_next;
    logic signed [gbmr_pkg::QUO_W-1:0]  quo_reg, quo_next;

    logic [gbmr_pkg::POS_W-1:0]         abs_val;
    logic [PROD_W-1:0]                  prod;
    logic [gbmr_pkg::POS_W-1:0]         quo_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        abs_val   = dividend[gbmr_pkg::POS_W-1] ? (~dividend + 1'b1) : dividend;
        prod      = PROD_W'(mag_reg) * PROD_W'(RECIP);
        quo_mag   = prod[SHIFT +: gbmr_pkg::POS_W];
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            neg_next = dividend[gbmr_pkg::POS_W-1];
            mag_next = abs_val;
        end
        else if (run_reg)
        begin
            // truncation toward zero: negate the magnitude quotient
            quo_next  = neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
            run_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/grid_brush_mask_rasterizer_core.sv -----
// sequence: the two reciprocal divisions and the cursor check, then for disc and ring the
// two radius squares and one squaring per grid column for the column distances, then per
// grid row a squaring through the shared squarer and a compare, then the final beat, plus stalls
// throughput: one request at a time, the input stalls until the final beat is issued;
// when the cursor is off the grid the final beat follows the cursor check directly
// reset: asynchronous active low, clears the sequencer, output valid and held row, grid to 64x64
module grid_brush_mask_rasterizer_core #(
    parameter int MAX_ROWS    = gbmr_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = gbmr_pkg::MAX_COLS_DEF,
    parameter int CELL_PIXELS = gbmr_pkg::CELL_PIXELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gbmr_pkg::KIND_W-1:0]         req_type,
    input  logic signed [gbmr_pkg::POS_W-1:0]   mouse_x,
    input  logic signed [gbmr_pkg::POS_W-1:0]   mouse_y,
    input  logic [gbmr_pkg::RAD_W-1:0]          radius,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gbmr_pkg::ROW_W-1:0]          row_index,
    output logic [gbmr_pkg::MASK_W-1:0]         col_mask,
    output logic                                last,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [gbmr_pkg::CFG_W-1:0]          cfg_value
);

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW  = gbmr_pkg::QUO_W;

    gbmr_pkg::state_t state_reg, state_next;

    logic [gbmr_pkg::CFG_W-1:0]        grid_rows_reg, grid_cols_reg;
    logic [gbmr_pkg::CFG_W-1:0]        rows_eff, cols_eff;

    logic [gbmr_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [gbmr_pkg::RAD_W-1:0]        rad_reg, rad_next;
    logic signed [gbmr_pkg::POS_W-1:0] my_reg, my_next;
    logic signed [QW-1:0]              ci_reg, ci_next;
    logic signed [QW-1:0]              cj_reg, cj_next;
    logic [CIW-1:0]                    col_reg, col_next;
    logic [RIW-1:0]                    row_reg, row_next;
    logic [gbmr_pkg::SQ_W-1:0]         rad2_reg, rad2_next;
    logic [gbmr_pkg::SQ_W-1:0]         rad1_reg, rad1_next;
    logic [gbmr_pkg::DIST_W-1:0]       dr2_reg, dr2_next;
    logic [gbmr_pkg::DIST_W-1:0]       dc2_reg [MAX_COLS];

    logic                              out_valid_reg, out_valid_next;
    logic [gbmr_pkg::ROW_W-1:0]        row_index_reg, row_index_next;
    logic [gbmr_pkg::MASK_W-1:0]       col_mask_reg, col_mask_next;
    logic                              last_reg, last_next;

    logic                              pend_valid_reg, pend_valid_next;
    logic [gbmr_pkg::ROW_W-1:0]        pend_row_reg, pend_row_next;
    logic [gbmr_pkg::MASK_W-1:0]       pend_mask_reg, pend_mask_next;

    logic                              div_start;
    logic signed [gbmr_pkg::POS_W-1:0] div_dividend;
    logic signed [QW-1:0]              div_quotient;
    gbmr_pkg::div_status_t             div_st;

    logic [gbmr_pkg::OP_W-1:0]         sq_op;
    logic signed [2*gbmr_pkg::OP_W-1:0] sq_full;
    logic [gbmr_pkg::SQ_W-1:0]         sq;

    logic [gbmr_pkg::MASK_W-1:0]       col_en;
    logic [gbmr_pkg::MASK_W-1:0]       disc_hit;
    logic [gbmr_pkg::MASK_W-1:0]       onehot;
    logic [gbmr_pkg::MASK_W-1:0]       row_mask;
    logic                              row_hit;
    logic                              cursor_in;
    logic                              out_free;
    logic                              in_accept;
    logic                              col_last, row_last;

    gbmr_divider #(
        .CELL_PIXELS(CELL_PIXELS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .quotient (div_quotient),
        .status   (div_st)
    );

    assign cfg_ready = 1'b1;
    assign rows_eff  = (grid_rows_reg > gbmr_pkg::CFG_W'(MAX_ROWS))
                       ? gbmr_pkg::CFG_W'(MAX_ROWS) : grid_rows_reg;
    assign cols_eff  = (grid_cols_reg > gbmr_pkg::CFG_W'(MAX_COLS))
                       ? gbmr_pkg::CFG_W'(MAX_COLS) : grid_cols_reg;

    assign in_stall  = (state_reg != gbmr_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign col_mask  = col_mask_reg;
    assign last      = last_reg;

    assign div_start    = in_accept || ((state_reg == gbmr_pkg::S_DIVX) && div_st.done);
    assign div_dividend = (state_reg == gbmr_pkg::S_IDLE) ? mouse_x : my_reg;

    // the one shared squarer: radius terms, column distances, then row distances
    always_comb
    begin
        case (state_reg)
            gbmr_pkg::S_RSQ:   sq_op = {1'b0, rad_reg};
            gbmr_pkg::S_RSQ1:  sq_op = {1'b0, rad_reg} - 1'b1;
            gbmr_pkg::S_CSQ:   sq_op = gbmr_pkg::OP_W'(col_reg) - cj_reg[gbmr_pkg::OP_W-1:0];
            gbmr_pkg::S_ROWSQ: sq_op = gbmr_pkg::OP_W'(row_reg) - ci_reg[gbmr_pkg::OP_W-1:0];
            default:           sq_op = '0;
        endcase
        sq_full = $signed(sq_op) * $signed(sq_op);
        sq      = sq_full[gbmr_pkg::SQ_W-1:0];
    end

    assign cursor_in = !ci_reg[QW-1] && (ci_reg[QW-2:0] < (QW - 1)'(rows_eff))
                    && !cj_reg[QW-1] && (cj_reg[QW-2:0] < (QW - 1)'(cols_eff));

    assign col_last = (gbmr_pkg::CFG_W'(col_reg) == (cols_eff - 1'b1));
    assign row_last = (gbmr_pkg::CFG_W'(row_reg) == (rows_eff - 1'b1));
    assign row_hit  = (ci_reg == QW'(row_reg));
    assign onehot   = gbmr_pkg::MASK_W'(1) << cj_reg[gbmr_pkg::ROW_W-1:0];

    for (genvar g = 0; g < gbmr_pkg::MASK_W; g++)
    begin : g_lane
        assign col_en[g] = (gbmr_pkg::CFG_W'(g) < cols_eff);
        if (g < MAX_COLS)
        begin : g_on
            logic [gbmr_pkg::DIST_W:0] d2;
            assign d2 = {1'b0, dr2_reg} + {1'b0, dc2_reg[g]};
            assign disc_hit[g] = col_en[g] && ({1'b0, d2} < rad2_reg)
                              && ((kind_reg == gbmr_pkg::KIND_DISC) || ({1'b0, d2} >= rad1_reg));
        end
        else
        begin : g_off
            assign disc_hit[g] = 1'b0;
        end
    end

    always_comb
    begin
        case (kind_reg)
            gbmr_pkg::KIND_CELL: row_mask = row_hit ? onehot : '0;
            gbmr_pkg::KIND_ROW:  row_mask = row_hit ? col_en : '0;
            gbmr_pkg::KIND_COL:  row_mask = onehot;
            gbmr_pkg::KIND_DISC: row_mask = disc_hit;
            gbmr_pkg::KIND_RING: row_mask = disc_hit;
            default:             row_mask = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbmr_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            grid_rows_reg  <= gbmr_pkg::GRID_RESET;
            grid_cols_reg  <= gbmr_pkg::GRID_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gbmr_pkg::CFG_ROWS: grid_rows_reg <= cfg_value;
                    gbmr_pkg::CFG_COLS: grid_cols_reg <= cfg_value;
                    default:            grid_rows_reg <= grid_rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        rad_reg       <= rad_next;
        my_reg        <= my_next;
        ci_reg        <= ci_next;
        cj_reg        <= cj_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        rad2_reg      <= rad2_next;
        rad1_reg      <= rad1_next;
        dr2_reg       <= dr2_next;
        row_index_reg <= row_index_next;
        col_mask_reg  <= col_mask_next;
        last_reg      <= last_next;
        pend_row_reg  <= pend_row_next;
        pend_mask_reg <= pend_mask_next;
        if (state_reg == gbmr_pkg::S_CSQ)
        begin
            dc2_reg[col_reg] <= sq[gbmr_pkg::DIST_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        rad_next        = rad_reg;
        my_next         = my_reg;
        ci_next         = ci_reg;
        cj_next         = cj_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        rad2_next       = rad2_reg;
        rad1_next       = rad1_reg;
        dr2_next        = dr2_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_mask_next  = pend_mask_reg;
        out_valid_next  = out_valid_reg && out_stall;
        row_index_next  = row_index_reg;
        col_mask_next   = col_mask_reg;
        last_next       = last_reg;

        case (state_reg)
            gbmr_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = req_type;
                    rad_next   = radius;
                    my_next    = mouse_y;
                    state_next = gbmr_pkg::S_DIVX;
                end
            end
            gbmr_pkg::S_DIVX:
            begin
                if (div_st.done)
                begin
                    cj_next    = div_quotient;
                    state_next = gbmr_pkg::S_DIVY;
                end
            end
            gbmr_pkg::S_DIVY:
            begin
                if (div_st.done)
                begin
                    ci_next    = div_quotient;
                    state_next = gbmr_pkg::S_CHECK;
                end
            end
            gbmr_pkg::S_CHECK:
            begin
                row_next = '0;
                col_next = '0;
                if (!cursor_in)
                begin
                    state_next = gbmr_pkg::S_FIN;
                end
                else if ((kind_reg == gbmr_pkg::KIND_DISC) || (kind_reg == gbmr_pkg::KIND_RING))
                begin
                    state_next = gbmr_pkg::S_RSQ;
                end
                else
                begin
                    state_next = gbmr_pkg::S_ROWSQ;
                end
            end
            gbmr_pkg::S_RSQ:
            begin
                rad2_next  = sq;
                state_next = gbmr_pkg::S_RSQ1;
            end
            gbmr_pkg::S_RSQ1:
            begin
                rad1_next  = sq;
                state_next = gbmr_pkg::S_CSQ;
            end
            gbmr_pkg::S_CSQ:
            begin
                col_next = col_reg + 1'b1;
                if (col_last)
                begin
                    state_next = gbmr_pkg::S_ROWSQ;
                end
            end
            gbmr_pkg::S_ROWSQ:
            begin
                dr2_next   = sq[gbmr_pkg::DIST_W-1:0];
                state_next = gbmr_pkg::S_CMP;
            end
            gbmr_pkg::S_CMP:
            begin
                // a held row goes out once a later non-empty row shows it is not last, else as the final beat
                if ((row_mask == '0) || !pend_valid_reg || out_free)
                begin
                    if (row_mask != '0)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            row_index_next = pend_row_reg;
                            col_mask_next  = pend_mask_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_row_next   = gbmr_pkg::ROW_W'(row_reg);
                        pend_mask_next  = row_mask;
                    end
                    row_next   = row_reg + 1'b1;
                    state_next = row_last ? gbmr_pkg::S_FIN : gbmr_pkg::S_ROWSQ;
                end
            end
            gbmr_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    row_index_next  = pend_valid_reg ? pend_row_reg : '0;
                    col_mask_next   = pend_valid_reg ? pend_mask_reg : '0;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = gbmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gbmr_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbmr_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("held row left over in idle");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> ((state_reg == gbmr_pkg::S_DIVX) || (state_reg == gbmr_pkg::S_DIVY)))
        else $error("divider running outside the division states");

    a_mask_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((col_mask_reg & ~col_en) == '0))
        else $error("mask bit beyond the columns in use");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (col_mask_reg == '0)) |-> (last_reg && (row_index_reg == '0)))
        else $error("empty mask beat that is not the single final result");
`endif

endmodule

// ----- sim/grid_brush_mask_rasterizer_core_tb.sv -----
module grid_brush_mask_rasterizer_core_tb;
    import gbmr_pkg::*;

    localparam int CELL_PX = CELL_PIXELS_DEF;
    localparam int TAIL_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_RING + 1'b1;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;

    // grid settings per random phase, including zero and values above the limit
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ROWS [PHASE_COUNT] = '{1, 127, 13, 64, 0, 64};
    localparam int PHASE_COLS [PHASE_COUNT] = '{1, 100, 64, 7, 37, 64};
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{40, 50, 40, 40, 10, 70};

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [RAD_W-1:0]        rad;
    } brush_req_t;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [MASK_W-1:0] mask;
        logic              last;
    } row_beat_t;

    class brush_scoreboard;
        row_beat_t        expected_rows[$];
        int unsigned      errors;
        logic [CFG_W-1:0] grid_rows;
        logic [CFG_W-1:0] grid_cols;

        function new();
            grid_rows = GRID_RESET;
            grid_cols = GRID_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_ROWS)
                grid_rows = value;
            else
                grid_cols = value;
        endfunction

        // rasterise one accepted request into its expected row beats
        function void note_request(brush_req_t rq);
            int rows, cols, ci, cj, rad, dr, dc, d2, r, c, last_row;
            logic [MASK_W-1:0] masks [MAX_ROWS_DEF];
            row_beat_t beat;
            rows = (grid_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(grid_rows);
            cols = (grid_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(grid_cols);
            ci = int'(rq.y);
            cj = int'(rq.x);
            ci = ci / CELL_PX;
            cj = cj / CELL_PX;
            rad = int'(rq.rad);
            for (r = 0; r < MAX_ROWS_DEF; r++)
                masks[r] = '0;
            if (ci >= 0 && ci < rows && cj >= 0 && cj < cols)
            begin
                case (rq.kind)
                    KIND_CELL: masks[ci][cj] = 1'b1;
                    KIND_ROW:
                        for (c = 0; c < cols; c++)
                            masks[ci][c] = 1'b1;
                    KIND_COL:
                        for (r = 0; r < rows; r++)
                            masks[r][cj] = 1'b1;
                    KIND_DISC, KIND_RING:
                        for (r = 0; r < rows; r++)
                        begin
                            dr = r - ci;
                            for (c = 0; c < cols; c++)
                            begin
                                dc = c - cj;
                                d2 = dr * dr + dc * dc;
                                // ring keeps only the outer band, radius 0 selects nothing
                                if (d2 < rad * rad
                                    && (rq.kind == KIND_DISC || d2 >= (rad - 1) * (rad - 1)))
                                    masks[r][c] = 1'b1;
                            end
                        end
                    default: ;
                endcase
            end
            last_row = -1;
            for (r = 0; r < rows; r++)
                if (masks[r] != '0)
                    last_row = r;
            if (last_row < 0)
            begin
                beat.row = '0;
                beat.mask = '0;
                beat.last = 1'b1;
                expected_rows.push_back(beat);
            end
            else
            begin
                for (r = 0; r <= last_row; r++)
                    if (masks[r] != '0)
                    begin
                        beat.row = r[ROW_W-1:0];
                        beat.mask = masks[r];
                        beat.last = (r == last_row);
                        expected_rows.push_back(beat);
                    end
            end
        endfunction

        function void check_beat(row_beat_t got);
            row_beat_t want;
            if (expected_rows.size() == 0)
            begin
                $error("row beat with nothing expected: row_index %0d col_mask %h last %0d",
                       got.row, got.mask, got.last);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (got.row !== want.row)
            begin
                $error("row_index: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.mask !== want.mask)
            begin
                $error("col_mask: expected %h, actual %h", want.mask, got.mask);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [KIND_W-1:0]       req_type = KIND_CELL;
    logic signed [POS_W-1:0] mouse_x = '0;
    logic signed [POS_W-1:0] mouse_y = '0;
    logic [RAD_W-1:0]        radius = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ROW_W-1:0]        row_index;
    logic [MASK_W-1:0]       col_mask;
    logic                    last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_index = CFG_ROWS;
    logic [CFG_W-1:0]        cfg_value = GRID_RESET;

    brush_scoreboard board = new();
    int unsigned requests_taken = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    grid_brush_mask_rasterizer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .mouse_x   (mouse_x),
        .mouse_y   (mouse_y),
        .radius    (radius),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_index (row_index),
        .col_mask  (col_mask),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_value (cfg_value)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_beat('{row_index, col_mask, last});
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    function automatic brush_req_t make_brush(logic [KIND_W-1:0] kind, int x, int y, int rad);
        brush_req_t rq;
        rq.kind = kind;
        rq.x = x[POS_W-1:0];
        rq.y = y[POS_W-1:0];
        rq.rad = rad[RAD_W-1:0];
        return rq;
    endfunction

    // mostly inside the grid, some just past an edge, some anywhere
    function automatic logic signed [POS_W-1:0] random_pixel(int cells);
        int pick, cell_no, v;
        pick = $urandom_range(0, 99);
        if (cells > 0 && pick < 80)
        begin
            cell_no = $urandom_range(0, cells - 1);
            if (cell_no == 0 && $urandom_range(0, 3) == 0)
                v = -int'($urandom_range(0, CELL_PX - 1));
            else
                v = cell_no * CELL_PX + int'($urandom_range(0, CELL_PX - 1));
        end
        else if (pick < 90)
        begin
            if ($urandom_range(0, 1))
                v = cells * CELL_PX + int'($urandom_range(0, CELL_PX - 1));
            else
                v = -CELL_PX - int'($urandom_range(0, CELL_PX - 1));
        end
        else
            v = $urandom;
        return v[POS_W-1:0];
    endfunction

    task automatic send_request(input brush_req_t rq);
        if (requests_taken < 90)
        begin
            sender_idle_pct = 29;
            receiver_stall_pct = 54;
        end
        else if (requests_taken < 180)
        begin
            sender_idle_pct = 54;
            receiver_stall_pct = 29;
        end
        else
        begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq.kind;
        mouse_x  <= rq.x;
        mouse_y  <= rq.y;
        radius   <= rq.rad;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(rq);
        requests_taken++;
    endtask

    task automatic drain_results();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_value <= rows_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(CFG_ROWS, rows_val);
        cfg_index <= CFG_COLS;
        cfg_value <= cols_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(CFG_COLS, cols_val);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #30_000_000;
        $display("grid_brush_mask_rasterizer_core: mismatch");
        $finish;
    end

    initial
    begin
        brush_req_t rq;
        int p, i, rows_eff, cols_eff, pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the 64 by 64 grid left by reset
        send_request(make_brush(KIND_CELL, 0, 0, 0));
        send_request(make_brush(KIND_CELL, 639, 639, 0));
        send_request(make_brush(KIND_CELL, 640, 5, 0));        // one column past the edge
        send_request(make_brush(KIND_ROW, -9, -1, 3));         // truncation towards zero
        send_request(make_brush(KIND_COL, -10, 20, 3));        // cell -1 is outside
        send_request(make_brush(KIND_ROW, 4095, 4095, 127));
        send_request(make_brush(KIND_DISC, -4096, -4096, 127));
        send_request(make_brush(KIND_ROW, 315, 200, 0));
        send_request(make_brush(KIND_COL, 5, 633, 0));
        send_request(make_brush(KIND_DISC, 320, 320, 0));      // empty selection
        send_request(make_brush(KIND_DISC, 320, 320, 1));
        send_request(make_brush(KIND_DISC, 320, 320, 5));
        send_request(make_brush(KIND_RING, 320, 320, 0));
        send_request(make_brush(KIND_RING, 320, 320, 1));
        send_request(make_brush(KIND_RING, 0, 0, 6));
        send_request(make_brush(KIND_RING, 637, 4, 9));
        send_request(make_brush(KIND_RING, 320, 320, 127));    // ring wider than the grid
        send_request(make_brush(KIND_DISC, 0, 0, 127));        // every row selected
        send_request(make_brush(KIND_SPARE_LO, 100, 100, 4));
        send_request(make_brush(KIND_SPARE_HI, 100, 100, 4));
        send_request(make_brush(KIND_CELL, 4095, -4096, 127));

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            in_valid <= 1'b0;
            drain_results();
            set_grid(CFG_W'(PHASE_ROWS[p]), CFG_W'(PHASE_COLS[p]));
            rows_eff = (PHASE_ROWS[p] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : PHASE_ROWS[p];
            cols_eff = (PHASE_COLS[p] > MAX_COLS_DEF) ? MAX_COLS_DEF : PHASE_COLS[p];
            for (i = 0; i < PHASE_ITEMS[p]; i++)
            begin
                // hold the sender back until every row beat is home
                if (i == PHASE_ITEMS[p] / 2 && (p == 1 || p == 5))
                begin
                    in_valid <= 1'b0;
                    drain_results();
                end
                if ($urandom_range(0, 99) < 8)
                    rq.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
                else
                    rq.kind = KIND_W'($urandom_range(KIND_CELL, KIND_RING));
                rq.x = random_pixel(cols_eff);
                rq.y = random_pixel(rows_eff);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    rq.rad = RAD_W'($urandom_range(0, 12));
                else if (pick < 90)
                    rq.rad = RAD_W'($urandom_range(0, 40));
                else
                    rq.rad = RAD_W'($urandom_range(0, (1 << RAD_W) - 1));
                send_request(rq);
            end
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("grid_brush_mask_rasterizer_core: match");
        else
            $display("grid_brush_mask_rasterizer_core: mismatch");
        $finish;
    end

endmodule

// ----- grid_brush_mask_rasterizer_core.f -----
hw/rtl/gbmr_pkg.sv
hw/rtl/gbmr_divider.sv
hw/rtl/grid_brush_mask_rasterizer_core.sv
sim/grid_brush_mask_rasterizer_core_tb.sv
